// File: hw/rtl/neighbour_sum_match_macros.svh
// assertion macros shared by the rtl of the neighbour sum block
`ifndef NEIGHBOUR_SUM_MATCH_MACROS_SVH
`define NEIGHBOUR_SUM_MATCH_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NSM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define NSM_ASSERT(lbl, clk, rst_n, prop, msg)
`define NSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hw/rtl/nsm_pkg.sv
// shared constants, register codes and window helpers of the neighbour sum block
package nsm_pkg;

	localparam int MAX_DIM_DEF    = 64;
	localparam int PIXEL_BITS_DEF = 16;
	localparam int SUM_BITS       = 19;
	localparam int DIM_REG_BITS   = 7;
	localparam int POS_BITS       = 6;
	localparam int CFG_IDX_BITS   = 2;
	localparam int WIN_CELLS      = 9;

	localparam logic [DIM_REG_BITS-1:0] DIM_RESET    = 7'd64;
	localparam logic [SUM_BITS-1:0]     TARGET_RESET = 19'd21;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FRAME_ROWS = 2'd0,
		REG_FRAME_COLS = 2'd1,
		REG_TARGET_SUM = 2'd2
	} cfg_reg_t;

	// which of the four positions of a window is emitted
	typedef enum logic [1:0] {
		POS_UP_LEFT  = 2'd0,
		POS_UP       = 2'd1,
		POS_LEFT     = 2'd2,
		POS_HERE     = 2'd3
	} pos_sel_t;

	// window cells (row major, bottom-right is the newest pixel) that neighbour a position
	function automatic logic [WIN_CELLS-1:0] nb_cells(pos_sel_t sel);
		logic [WIN_CELLS-1:0] m;
		unique case (sel)
			POS_UP_LEFT: m = 9'b111101111;
			POS_UP:      m = 9'b110010110;
			POS_LEFT:    m = 9'b101111000;
			POS_HERE:    m = 9'b010110000;
			default:     m = '0;
		endcase
		return m;
	endfunction

endpackage

// File: hw/rtl/neighbour_sum_match.sv
// Eight-neighbour sum over a raster stream with target compare. Pixels of a
// frame_rows by frame_cols frame enter in raster order; a two-row line buffer
// (one synchronous memory of MAX_DIM words, each holding the two previous rows
// of a column, one read and one write per cycle) feeds a 3x3 window. Each
// position yields one result as soon as its last neighbour is in, so an input
// causes zero to four results. Results leave through a sequencer that forms
// one neighbour sum per cycle unless out_ready holds it: a pixel that releases
// zero or one result does not stall the input, so the input takes one pixel
// per cycle unless the output stalls, while a pixel that releases n results
// holds the sequencer for one sum per result and stalls the input until the
// last is formed. A result passes the stage 1 register, the sequencer snapshot
// and the output register, and one that waits on out_ready holds back all
// behind it. No clearing pass is needed after reset.
`include "neighbour_sum_match_macros.svh"

module neighbour_sum_match #(
	parameter int MAX_DIM    = nsm_pkg::MAX_DIM_DEF,
	parameter int PIXEL_BITS = nsm_pkg::PIXEL_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [nsm_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [nsm_pkg::SUM_BITS-1:0]          cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [PIXEL_BITS-1:0]          pixel_value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [nsm_pkg::POS_BITS-1:0]          pos_row,
	output logic [nsm_pkg::POS_BITS-1:0]          pos_col,
	output logic signed [nsm_pkg::SUM_BITS-1:0]   neighbour_total,
	output logic                                  is_match,
	output logic                                  last_of_run,
	output logic                                  frame_done,
	output logic                                  none_matched
);

	localparam int IW = $clog2(MAX_DIM);
	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int PB = PIXEL_BITS;
	localparam int CW = (PB + 3 > nsm_pkg::SUM_BITS) ? PB + 3 : nsm_pkg::SUM_BITS;
	localparam int NC = nsm_pkg::WIN_CELLS;

	// configuration registers
	logic [nsm_pkg::DIM_REG_BITS-1:0]   rows_q, cols_q;
	logic signed [nsm_pkg::SUM_BITS-1:0] target_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= nsm_pkg::DIM_RESET;
			cols_q   <= nsm_pkg::DIM_RESET;
			target_q <= nsm_pkg::TARGET_RESET;
		end else if (cfg_we) begin
			unique case (nsm_pkg::cfg_reg_t'(cfg_index))
				nsm_pkg::REG_FRAME_ROWS: rows_q   <= cfg_data[nsm_pkg::DIM_REG_BITS-1:0];
				nsm_pkg::REG_FRAME_COLS: cols_q   <= cfg_data[nsm_pkg::DIM_REG_BITS-1:0];
				nsm_pkg::REG_TARGET_SUM: target_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective dimensions, clamped to 1..MAX_DIM
	logic [DW-1:0] rows_eff, cols_eff;

	always_comb begin
		if (rows_q == '0) begin
			rows_eff = DW'(1);
		end else if (32'(rows_q) > MAX_DIM) begin
			rows_eff = DW'(MAX_DIM);
		end else begin
			rows_eff = DW'(rows_q);
		end
		if (cols_q == '0) begin
			cols_eff = DW'(1);
		end else if (32'(cols_q) > MAX_DIM) begin
			cols_eff = DW'(MAX_DIM);
		end else begin
			cols_eff = DW'(cols_q);
		end
	end

	// pipeline control
	logic v_s1, s1_go, s2_busy, s2_fire, s2_last, s2_done, out_free, acc;
	logic [3:0] mask_s2;

	// raster position of the next pixel
	logic [IW-1:0] row_q, col_q, r_now, c_now;
	logic          restart, last_col, last_row;

	always_comb begin
		restart  = (DW'(row_q) >= rows_eff) || (DW'(col_q) >= cols_eff);
		r_now    = restart ? '0 : row_q;
		c_now    = restart ? '0 : col_q;
		last_col = (DW'(c_now) == cols_eff - DW'(1));
		last_row = (DW'(r_now) == rows_eff - DW'(1));
	end

	assign acc      = in_valid && in_ready;
	assign in_ready = !v_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : r_now + IW'(1);
			end else begin
				col_q <= c_now + IW'(1);
				row_q <= r_now;
			end
		end
	end

	// stage 1 transaction
	logic signed [PB-1:0]  px_s1;
	logic [IW-1:0]         r_s1, c_s1;
	logic [3:0]            em_s1;
	logic [2:0]            rok_s1, cok_s1;
	logic                  first_s1, byp_s1;
	logic [2*PB-1:0]       bypd_s1, rd_q, entry, wdata;
	logic signed [PB-1:0]  newer, older;

	always_comb begin
		entry = byp_s1 ? bypd_s1 : rd_q;
		newer = entry[2*PB-1:PB];
		older = entry[PB-1:0];
		wdata = {px_s1, newer};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1    <= pixel_value;
			r_s1     <= r_now;
			c_s1     <= c_now;
			em_s1    <= {last_row && last_col, last_row && (c_now != '0),
				(r_now != '0) && last_col, (r_now != '0) && (c_now != '0)};
			rok_s1   <= {1'b1, r_now != '0, r_now > IW'(1)};
			cok_s1   <= {1'b1, c_now != '0, c_now > IW'(1)};
			first_s1 <= (r_now == '0) && (c_now == '0);
			byp_s1   <= s1_go && (c_s1 == c_now);
			bypd_s1  <= wdata;
		end
	end

	// line buffer: per column the two previous rows, newer in the upper half
	logic [2*PB-1:0] line_mem [MAX_DIM];

	always_ff @(posedge clk) begin
		if (s1_go) begin
			line_mem[c_s1] <= wdata;
		end
		if (acc) begin
			rd_q <= line_mem[c_now];
		end
	end

	// 3x3 window and masked snapshot for the sequencer
	logic signed [PB-1:0] win_q [NC];
	logic signed [PB-1:0] win_nx [NC];
	logic signed [PB-1:0] snap_s2 [NC];
	logic [IW-1:0]        r_s2, c_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_nx[i*3]     = win_q[i*3+1];
			win_nx[i*3 + 1] = win_q[i*3+2];
		end
		win_nx[2] = older;
		win_nx[5] = newer;
		win_nx[8] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NC; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_go) begin
			win_q <= win_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			for (int i = 0; i < NC; i++) begin
				snap_s2[i] <= (rok_s1[i/3] && cok_s1[i%3]) ? win_nx[i] : '0;
			end
			r_s2 <= r_s1;
			c_s2 <= c_s1;
		end
	end

	// result sequencer: one position per cycle while the output is free, lowest pending first
	nsm_pkg::pos_sel_t pick;
	logic [3:0]           pick_oh;
	logic [NC-1:0]        sel;
	logic signed [CW-1:0] sum;
	logic                 match;
	logic [IW-1:0]        pr, pc;
	logic                 any_q;

	always_comb begin
		priority if (mask_s2[0]) begin
			pick = nsm_pkg::POS_UP_LEFT;
		end else if (mask_s2[1]) begin
			pick = nsm_pkg::POS_UP;
		end else if (mask_s2[2]) begin
			pick = nsm_pkg::POS_LEFT;
		end else begin
			pick = nsm_pkg::POS_HERE;
		end
		pick_oh = 4'b0001 << pick;
		sel     = nsm_pkg::nb_cells(pick);
		sum     = '0;
		for (int i = 0; i < NC; i++) begin
			if (sel[i]) begin
				sum = sum + CW'(snap_s2[i]);
			end
		end
		match = (sum == CW'(target_q));
		pr    = (pick == nsm_pkg::POS_UP_LEFT || pick == nsm_pkg::POS_UP) ?
			r_s2 - IW'(1) : r_s2;
		pc    = (pick == nsm_pkg::POS_UP_LEFT || pick == nsm_pkg::POS_LEFT) ?
			c_s2 - IW'(1) : c_s2;
	end

	assign s2_busy  = mask_s2 != '0;
	assign out_free = !out_valid || out_ready;
	assign s2_fire  = s2_busy && out_free;
	assign s2_last  = (mask_s2 & ~pick_oh) == '0;
	assign s2_done  = s2_fire && s2_last;
	assign s1_go    = v_s1 && (!s2_busy || s2_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
			any_q   <= 1'b0;
		end else begin
			if (s1_go) begin
				mask_s2 <= em_s1;
			end else if (s2_fire) begin
				mask_s2 <= mask_s2 & ~pick_oh;
			end
			// a frame's first pixel clears the match history
			if (s1_go && first_s1) begin
				any_q <= 1'b0;
			end else if (s2_fire && match) begin
				any_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= s2_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_fire) begin
			pos_row         <= nsm_pkg::POS_BITS'(pr);
			pos_col         <= nsm_pkg::POS_BITS'(pc);
			neighbour_total <= sum[nsm_pkg::SUM_BITS-1:0];
			is_match        <= match;
			last_of_run     <= s2_last;
			frame_done      <= s2_last && (pick == nsm_pkg::POS_HERE);
			none_matched    <= s2_last && (pick == nsm_pkg::POS_HERE) && !(any_q || match);
		end
	end

	// checks
	`NSM_ASSERT(a_done_is_last, clk, arst_n, out_valid && frame_done |-> last_of_run, "frame end not last")
	`NSM_ASSERT(a_none_with_done, clk, arst_n, out_valid && none_matched |-> frame_done, "none_matched without frame end")
	`NSM_ASSERT(a_s1_stall_cause, clk, arst_n, v_s1 && !s1_go |-> s2_busy, "stage 1 stalled with idle sequencer")
	`NSM_ASSERT_NEXT(a_run_continues, clk, arst_n, s2_fire && !s2_last, s2_busy, "result run cut short")

endmodule

// File: test/neighbour_sum_match_test.sv
// self-checking testbench of the neighbour sum block with a scoreboard class
`timescale 1ns / 100ps

module neighbour_sum_match_test;

	typedef struct {
		logic [nsm_pkg::POS_BITS-1:0]        row;
		logic [nsm_pkg::POS_BITS-1:0]        col;
		logic signed [nsm_pkg::SUM_BITS-1:0] total;
		logic                                match;
		logic                                last;
		logic                                done;
		logic                                none;
	} nb_result_t;

	// scoreboard: predicts neighbour sums and checks results against them
	class nb_sum_scoreboard;
		int unsigned   rows_cfg, cols_cfg;
		longint        target;
		longint        line_buf[2*nsm_pkg::MAX_DIM_DEF];
		longint        win[9];
		int unsigned   cur_row, cur_col;
		bit            seen_match;
		nb_result_t    pending[$];
		int            errors;
		int            checked;

		function void clear();
			rows_cfg = 64;
			cols_cfg = 64;
			target = 21;
			foreach (line_buf[i]) line_buf[i] = 0;
			foreach (win[i]) win[i] = 0;
			cur_row = 0;
			cur_col = 0;
			seen_match = 0;
			pending.delete();
			errors = 0;
			checked = 0;
		endfunction

		function void set_reg(nsm_pkg::cfg_reg_t idx, logic [nsm_pkg::SUM_BITS-1:0] val);
			case (idx)
				nsm_pkg::REG_FRAME_ROWS: rows_cfg = val[nsm_pkg::DIM_REG_BITS-1:0];
				nsm_pkg::REG_FRAME_COLS: cols_cfg = val[nsm_pkg::DIM_REG_BITS-1:0];
				nsm_pkg::REG_TARGET_SUM: target = longint'($signed(val));
				default: ;
			endcase
		endfunction

		function longint cell_at(longint nr, longint nc, longint r, longint c,
				longint nrows, longint ncols);
			longint wr, wc;
			if (nr < 0 || nr >= nrows || nc < 0 || nc >= ncols) return 0;
			wr = nr - (r - 2);
			wc = nc - (c - 2);
			if (wr < 0 || wr > 2 || wc < 0 || wc > 2) return 0;
			return win[wr*3 + wc];
		endfunction

		function void add_result(longint pr, longint pc, longint r, longint c,
				longint nrows, longint ncols, bit last, bit done);
			int dr[8] = '{1, 1, 0, -1, -1, -1, 0, 1};
			int dc[8] = '{0, 1, 1, 1, 0, -1, -1, -1};
			longint sum;
			nb_result_t e;
			sum = 0;
			for (int d = 0; d < 8; d++)
				sum += cell_at(pr + dr[d], pc + dc[d], r, c, nrows, ncols);
			e.match = (sum == target);
			if (e.match) seen_match = 1;
			e.row = pr[nsm_pkg::POS_BITS-1:0];
			e.col = pc[nsm_pkg::POS_BITS-1:0];
			e.total = sum[nsm_pkg::SUM_BITS-1:0];
			e.last = last;
			e.done = done;
			e.none = done && !seen_match;
			pending.push_back(e);
		endfunction

		// note an accepted pixel and queue the results it releases
		function void note_pixel(logic signed [15:0] px);
			longint nrows, ncols, r, c, older, newer;
			longint pr[4], pc[4];
			int n, sa, sb;
			bit fend;
			nrows = rows_cfg < 1 ? 1 : (rows_cfg > 64 ? 64 : rows_cfg);
			ncols = cols_cfg < 1 ? 1 : (cols_cfg > 64 ? 64 : cols_cfg);
			if (cur_row >= nrows || cur_col >= ncols) begin
				cur_row = 0;
				cur_col = 0;
				seen_match = 0;
			end
			r = cur_row;
			c = cur_col;
			sa = (cur_row & 1) * nsm_pkg::MAX_DIM_DEF + cur_col;
			sb = ((cur_row + 1) & 1) * nsm_pkg::MAX_DIM_DEF + cur_col;
			older = line_buf[sa];
			newer = line_buf[sb];
			line_buf[sa] = px;
			for (int i = 0; i < 3; i++) begin
				win[i*3] = win[i*3 + 1];
				win[i*3 + 1] = win[i*3 + 2];
			end
			win[2] = older;
			win[5] = newer;
			win[8] = px;
			n = 0;
			if (r >= 1 && c >= 1) begin pr[n] = r - 1; pc[n] = c - 1; n++; end
			if (r >= 1 && c == ncols - 1) begin pr[n] = r - 1; pc[n] = c; n++; end
			if (r == nrows - 1 && c >= 1) begin pr[n] = r; pc[n] = c - 1; n++; end
			if (r == nrows - 1 && c == ncols - 1) begin pr[n] = r; pc[n] = c; n++; end
			fend = (r == nrows - 1 && c == ncols - 1);
			for (int k = 0; k < n; k++)
				add_result(pr[k], pc[k], r, c, nrows, ncols, k == n - 1, fend && k == n - 1);
			if (c + 1 >= ncols) begin
				cur_col = 0;
				if (r + 1 >= nrows) begin
					cur_row = 0;
					seen_match = 0;
				end else begin
					cur_row = r + 1;
				end
			end else begin
				cur_col = c + 1;
			end
		endfunction

		// compare one accepted result with the oldest prediction
		function void check_result(nb_result_t got);
			nb_result_t e;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result row %0d col %0d total %0d", $time,
					got.row, got.col, got.total);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.row !== e.row) begin
				$display("%0t: pos_row expected %0d actual %0d", $time, e.row, got.row);
				errors++;
			end
			if (got.col !== e.col) begin
				$display("%0t: pos_col expected %0d actual %0d", $time, e.col, got.col);
				errors++;
			end
			if (got.total !== e.total) begin
				$display("%0t: neighbour_total expected %0d actual %0d", $time,
					e.total, got.total);
				errors++;
			end
			if (got.match !== e.match) begin
				$display("%0t: is_match expected %0b actual %0b", $time, e.match, got.match);
				errors++;
			end
			if (got.last !== e.last) begin
				$display("%0t: last_of_run expected %0b actual %0b", $time, e.last, got.last);
				errors++;
			end
			if (got.done !== e.done) begin
				$display("%0t: frame_done expected %0b actual %0b", $time, e.done, got.done);
				errors++;
			end
			if (got.none !== e.none) begin
				$display("%0t: none_matched expected %0b actual %0b", $time, e.none, got.none);
				errors++;
			end
		endfunction
	endclass

	logic                                 clk;
	logic                                 arst_n;
	logic                                 cfg_we;
	logic [nsm_pkg::CFG_IDX_BITS-1:0]     cfg_index;
	logic [nsm_pkg::SUM_BITS-1:0]         cfg_data;
	logic                                 in_valid;
	logic                                 in_ready;
	logic signed [15:0]                   pixel_value;
	logic                                 out_valid;
	logic                                 out_ready;
	logic [nsm_pkg::POS_BITS-1:0]         pos_row;
	logic [nsm_pkg::POS_BITS-1:0]         pos_col;
	logic signed [nsm_pkg::SUM_BITS-1:0]  neighbour_total;
	logic                                 is_match;
	logic                                 last_of_run;
	logic                                 frame_done;
	logic                                 none_matched;

	nb_sum_scoreboard sb;
	bit               stim_done;
	bit               rx_idle_off;
	int               pixels_sent;
	int               frames_seen;
	int               match_hits;

	neighbour_sum_match u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .pixel_value(pixel_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.pos_row(pos_row), .pos_col(pos_col), .neighbour_total(neighbour_total),
		.is_match(is_match), .last_of_run(last_of_run), .frame_done(frame_done),
		.none_matched(none_matched)
	);

	// clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// write one configuration register
	task automatic write_reg(nsm_pkg::cfg_reg_t idx, logic [nsm_pkg::SUM_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// send one pixel transaction after a random gap unless no_gap is set; valid stays high after acceptance
	task automatic send_pixel(logic signed [15:0] px, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_value <= px;
		do @(posedge clk); while (!in_ready);
		sb.note_pixel(px);
		pixels_sent++;
	endtask

	// wait for all predicted results, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_pixel();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return $signed(16'($urandom_range(0, 6)));
			default: return $signed(16'($urandom));
		endcase
	endfunction

	// stream a whole frame
	task automatic send_frame(int nrows, int ncols, bit burst);
		int cnt;
		cnt = (nrows < 1 ? 1 : (nrows > 64 ? 64 : nrows))
			* (ncols < 1 ? 1 : (ncols > 64 ? 64 : ncols));
		for (int i = 0; i < cnt; i++)
			send_pixel(rand_pixel(), burst);
	endtask

	// result receiver with random stalls unless rx_idle_off is set
	initial begin
		int stall;
		nb_result_t got;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rx_idle_off ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got.row = pos_row;
			got.col = pos_col;
			got.total = neighbour_total;
			got.match = is_match;
			got.last = last_of_run;
			got.done = frame_done;
			got.none = none_matched;
			if (got.done) frames_seen++;
			if (got.match) match_hits++;
			sb.check_result(got);
		end
	end

	// stimulus
	initial begin
		int nr, nc;
		sb = new();
		sb.clear();
		stim_done = 0;
		rx_idle_off = 0;
		pixels_sent = 0;
		frames_seen = 0;
		match_hits = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = nsm_pkg::REG_FRAME_ROWS;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel_value = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes and all-equal frames that hit the target
		write_reg(nsm_pkg::REG_FRAME_ROWS, 3);
		write_reg(nsm_pkg::REG_FRAME_COLS, 3);
		write_reg(nsm_pkg::REG_TARGET_SUM, 19'sd24);
		for (int i = 0; i < 9; i++) send_pixel(16'sd3, 0);
		drain();
		write_reg(nsm_pkg::REG_TARGET_SUM, 19'h40000);
		write_reg(nsm_pkg::REG_FRAME_ROWS, 0);
		write_reg(nsm_pkg::REG_FRAME_COLS, 0);
		send_pixel(16'sh7fff, 0);
		send_pixel(16'sh8000, 0);
		drain();
		write_reg(nsm_pkg::REG_FRAME_ROWS, 127);
		write_reg(nsm_pkg::REG_FRAME_COLS, 1);
		write_reg(nsm_pkg::REG_TARGET_SUM, 19'h3fff8);
		for (int i = 0; i < 5; i++) send_pixel(16'sh8000, 0);
		drain();
		write_reg(nsm_pkg::REG_FRAME_ROWS, 2);
		write_reg(nsm_pkg::REG_FRAME_COLS, 2);
		write_reg(nsm_pkg::REG_TARGET_SUM, 19'sd98301);
		for (int i = 0; i < 4; i++) send_pixel(16'sh7fff, 0);
		drain();

		// random frames, mostly with small dimensions, then one 64 by 3 frame at the end
		while (pixels_sent < 150) begin
			nr = $urandom_range(1, 6);
			nc = $urandom_range(1, 8);
			if ($urandom_range(0, 9) == 0) nr = $urandom_range(65, 127);
			if (nr > 64) nc = 1;
			write_reg(nsm_pkg::REG_FRAME_ROWS, 19'(nr));
			write_reg(nsm_pkg::REG_FRAME_COLS, 19'(nc));
			write_reg(nsm_pkg::REG_TARGET_SUM, $urandom_range(0, 3) == 0 ?
				19'($urandom) : 19'($urandom_range(0, 20)));
			rx_idle_off = ($urandom_range(0, 3) == 0);
			for (int f = 0; f < 2; f++) send_frame(nr, nc, rx_idle_off);
			drain();
		end
		rx_idle_off = 0;
		write_reg(nsm_pkg::REG_FRAME_ROWS, 64);
		write_reg(nsm_pkg::REG_FRAME_COLS, 3);
		write_reg(nsm_pkg::REG_TARGET_SUM, 21);
		send_frame(64, 3, 1);
		drain();
		stim_done = 1;
	end

	// final report
	initial begin
		wait (stim_done);
		$display("pixels sent %0d, results checked %0d, frames closed %0d, matches %0d",
			pixels_sent, sb.checked, frames_seen, match_hits);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// run limit
	initial begin
		#4000000;
		$display("timeout");
		$display("Test completed with failures");
		$finish;
	end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/nsm_pkg.sv
hw/rtl/neighbour_sum_match.sv
test/neighbour_sum_match_test.sv
